// ===== rtl/bpc_pkg.sv =====
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared widths, constants and types of the barometric pressure compensation.
// ----------------------------------------------------------------------------
package bpc_pkg;

  localparam int CAL_W   = 16;   // calibration word
  localparam int X_W     = 24;   // raw pressure
  localparam int TR_W    = 16;   // raw temperature
  localparam int TT_W    = 31;   // squared centered temperature
  localparam int PP_W    = CAL_W + TT_W;
  localparam int PT_W    = 53;   // table point, 24 fractional bits
  localparam int D_W     = 58;   // signed denominator of C
  localparam int BX_W    = X_W + 24;
  localparam int OPA_W   = 97;   // signed multiplier operand A
  localparam int OPB_W   = 65;   // signed multiplier operand B
  localparam int PROD_W  = 128;
  localparam int PRESS_W = 21;
  localparam int TEMP_W  = 15;
  localparam int DIV_BITS = 22;  // quotient bits kept before overflow
  localparam int DIVC_W  = 5;
  localparam int DSH_W   = PROD_W + 2;
  localparam int QUEUE_DEPTH = 2;

  localparam int OFFSET_SHIFT = 35;
  localparam logic [PT_W-1:0] LOW_BASE   = PT_W'(64'd7 << 43);
  localparam logic [PT_W-1:0] UPPER_BASE = PT_W'(64'd23 << 43);

  localparam logic [DIV_BITS:0]  P0_SIXTEENTHS = 23'd720000;
  localparam logic [DIV_BITS:0]  POS_LIMIT     = 23'd1377151;
  localparam logic [PRESS_W-1:0] PRESS_MAX     = 21'h1FFFFF;
  localparam logic [OPB_W-1:0]   NUM_FACTOR    = 65'd6720000;

  localparam logic [31:0]        TEMP_SCALE  = 32'd17500;
  localparam logic [31:0]        TEMP_ROUND  = 32'd32768;
  localparam logic signed [15:0] TEMP_OFFSET = 16'sd4500;

  typedef enum logic [1:0] {
    CFG_CAL_ZERO  = 2'd0,
    CFG_CAL_ONE   = 2'd1,
    CFG_CAL_TWO   = 2'd2,
    CFG_CAL_THREE = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [CAL_W-1:0] zero;
    logic [CAL_W-1:0] one;
    logic [CAL_W-1:0] two;
    logic [CAL_W-1:0] three;
  } bpc_cal_t;

  // Classified request handed from the front to the back.
  typedef struct packed {
    logic [X_W-1:0]    x;
    logic [PT_W-1:0]   l0;
    logic [PT_W-1:0]   l1;
    logic [PT_W-1:0]   l2;
    logic [D_W-1:0]    d;
    logic              err;
    logic [TEMP_W-1:0] temp;
  } bpc_item_t;

endpackage

// ===== rtl/bpc_front.sv =====
// ----------------------------------------------------------------------------
// bpc_front
// Three-stage front: temperature, table points, denominator and zero checks.
// ----------------------------------------------------------------------------
module bpc_front import bpc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  bpc_cal_t         cal,
  input  logic [X_W-1:0]   raw_pressure,
  input  logic [TR_W-1:0]  raw_temperature,
  input  logic             in_valid,
  output logic             in_ready,
  output bpc_item_t        item,
  output logic             item_valid,
  input  logic             item_ready
);

  logic adv;
  logic v1, v2, v3;

  logic signed [TR_W-1:0] t_c;
  logic signed [31:0]     t_sq;
  logic [31:0]            temp_prod;
  logic signed [15:0]     temp_w;

  logic [X_W-1:0]    x1, x2, x3;
  logic [TT_W-1:0]   tt1;
  logic [TEMP_W-1:0] temp1, temp2, temp3;
  logic [PT_W-1:0]   l0_2, l1_2, l2_2, l0_3, l1_3, l2_3;
  logic [PP_W-1:0]   p0, p1, p2;
  logic [D_W-1:0]    d_c, d3;

  // advance the whole pipe unless the last stage is blocked
  assign adv      = !v3 || item_ready;
  assign in_ready = adv;

  assign t_c       = signed'({~raw_temperature[TR_W-1], raw_temperature[TR_W-2:0]});
  assign t_sq      = t_c * t_c;
  assign temp_prod = 32'(raw_temperature) * TEMP_SCALE + TEMP_ROUND;
  assign temp_w    = signed'({1'b0, temp_prod[30:16]}) - TEMP_OFFSET;

  assign p0 = PP_W'(cal.zero) * PP_W'(tt1);
  assign p1 = PP_W'(cal.one)  * PP_W'(tt1);
  assign p2 = PP_W'(cal.two)  * PP_W'(tt1);

  assign d_c = D_W'(l1_2) * D_W'(12) - D_W'(l2_2) * D_W'(7) - D_W'(l0_2) * D_W'(5);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x1    <= raw_pressure;
      tt1   <= t_sq[TT_W-1:0];
      temp1 <= temp_w[TEMP_W-1:0];
      x2    <= x1;
      temp2 <= temp1;
      l0_2  <= LOW_BASE + PT_W'(p0);
      l1_2  <= (PT_W'(cal.three) << OFFSET_SHIFT) + PT_W'(p1);
      l2_2  <= UPPER_BASE + PT_W'(p2);
      x3    <= x2;
      temp3 <= temp2;
      l0_3  <= l0_2;
      l1_3  <= l1_2;
      l2_3  <= l2_2;
      d3    <= d_c;
    end
  end

  assign item_valid = v3;
  always_comb begin
    item.x    = x3;
    item.l0   = l0_3;
    item.l1   = l1_3;
    item.l2   = l2_3;
    item.d    = d3;
    item.err  = (d3 == '0) || (l0_3 == l1_3);
    item.temp = temp3;
  end

endmodule

// ===== rtl/bpc_fifo.sv =====
// ----------------------------------------------------------------------------
// bpc_fifo
// Short request queue between front and back.
// ----------------------------------------------------------------------------
module bpc_fifo import bpc_pkg::*; #(
  parameter int Depth = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  bpc_item_t wr_data,
  input  logic      wr_valid,
  output logic      wr_ready,
  output bpc_item_t rd_data,
  output logic      rd_valid,
  input  logic      rd_ready
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  bpc_item_t       mem [Depth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;
  logic            push, pop;

  assign wr_ready = count != CntW'(Depth);
  assign rd_valid = count != '0;
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CntW'(push) - CntW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

// ===== rtl/bpc_mul.sv =====
// ----------------------------------------------------------------------------
// bpc_mul
// Signed 97 x 65 multiplier built from one 32 x 32 unit over six passes.
// ----------------------------------------------------------------------------
module bpc_mul import bpc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [OPA_W-1:0]  a,
  input  logic signed [OPB_W-1:0]  b,
  output logic                     done,
  output logic signed [PROD_W-1:0] p
);

  localparam logic [2:0] LAST = 3'd6;

  logic [OPA_W-1:0]  a_abs;
  logic [OPB_W-1:0]  b_abs;
  logic [OPA_W-2:0]  am;
  logic [OPB_W-2:0]  bm;
  logic              neg, busy, pv;
  logic [2:0]        k, pk;
  logic [63:0]       pr;
  logic [31:0]       a_ch, b_ch;
  logic [1:0]        sh;
  logic [PROD_W-1:0] acc, pp_sh;

  assign a_abs = a[OPA_W-1] ? OPA_W'(-a) : OPA_W'(a);
  assign b_abs = b[OPB_W-1] ? OPB_W'(-b) : OPB_W'(b);
  assign a_ch  = am[{k[2:1], 5'b0} +: 32];
  assign b_ch  = bm[{k[0], 5'b0} +: 32];
  assign sh    = pk[2:1] + {1'b0, pk[0]};
  assign pp_sh = PROD_W'(pr) << {sh, 5'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pv   <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        pv   <= 1'b0;
      end else if (busy) begin
        pv <= (k != LAST);
        if (k == LAST && !pv) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      am  <= a_abs[OPA_W-2:0];
      bm  <= b_abs[OPB_W-2:0];
      neg <= a[OPA_W-1] ^ b[OPB_W-1];
      acc <= '0;
      k   <= '0;
    end else if (busy) begin
      if (k != LAST) begin
        pr <= a_ch * b_ch;
        pk <= k;
        k  <= k + 1'b1;
      end
      if (pv) begin
        acc <= acc + pp_sh;
      end
      if (k == LAST && !pv) begin
        p <= neg ? signed'(-acc) : signed'(acc);
      end
    end
  end

endmodule

// ===== rtl/bpc_back.sv =====
// ----------------------------------------------------------------------------
// bpc_back
// Sequencer: conversion constants, rounding division and the result register.
// ----------------------------------------------------------------------------
module bpc_back import bpc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  bpc_item_t                item,
  input  logic                     item_valid,
  output logic                     item_ready,
  output logic [PRESS_W-1:0]       pressure_sixteenth_pa,
  output logic signed [TEMP_W-1:0] temperature_centi_c,
  output logic                     calc_error,
  output logic                     out_valid,
  input  logic                     out_ready
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_MSTART = 10'b0000000010,
    S_MWAIT  = 10'b0000000100,
    S_NORM   = 10'b0000001000,
    S_TOP    = 10'b0000010000,
    S_ABS    = 10'b0000100000,
    S_CHK    = 10'b0001000000,
    S_DIV    = 10'b0010000000,
    S_FIN    = 10'b0100000000,
    S_OUT    = 10'b1000000000
  } state_t;

  typedef enum logic [2:0] {
    OP_N_LOW = 3'd0,
    OP_N_MID = 3'd1,
    OP_N_UP  = 3'd2,
    OP_DEN   = 3'd3,
    OP_SPAN  = 3'd4,
    OP_NUM   = 3'd5
  } op_t;

  state_t state;
  op_t    op;

  logic [PT_W-1:0]          l0, l1, l2;
  logic signed [D_W-1:0]    d;
  logic [BX_W-1:0]          bx;
  logic [TEMP_W-1:0]        temp;
  logic signed [PROD_W-1:0] accn, den, num, top;
  logic signed [OPA_W-1:0]  e;
  logic [DSH_W-1:0]         dsh;
  logic                     neg;
  logic [DIV_BITS-1:0]      q;
  logic [DIV_BITS:0]        qa;
  logic [DIVC_W-1:0]        cnt;
  logic [PRESS_W-1:0]       res_press;
  logic                     res_err;
  logic                     load;

  logic                     mul_start, mul_done;
  logic signed [OPA_W-1:0]  mul_a;
  logic signed [OPB_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] mul_p;

  bpc_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  assign mul_start  = (state == S_MSTART);
  assign item_ready = (state == S_IDLE);
  assign load       = (state == S_OUT) && (!out_valid || out_ready);
  assign qa         = {1'b0, q} + (DIV_BITS + 1)'(neg && (top != '0));

  always_comb begin
    unique case (op)
      OP_N_LOW: begin
        mul_a = signed'(OPA_W'(l0) * OPA_W'(12));
        mul_b = signed'(OPB_W'(l2));
      end
      OP_N_MID: begin
        mul_a = signed'(OPA_W'(l0) * OPA_W'(7));
        mul_b = signed'(OPB_W'(l1));
      end
      OP_N_UP: begin
        mul_a = signed'(OPA_W'(l2) * OPA_W'(5));
        mul_b = signed'(OPB_W'(l1));
      end
      OP_DEN: begin
        mul_a = OPA_W'(d);
        mul_b = signed'(OPB_W'(bx));
      end
      OP_SPAN: begin
        mul_a = signed'(OPA_W'(bx)) - signed'(OPA_W'(l0));
        mul_b = signed'(NUM_FACTOR);
      end
      OP_NUM: begin
        mul_a = e;
        mul_b = signed'(OPB_W'(l1)) - signed'(OPB_W'(l2));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      op        <= OP_N_LOW;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            op    <= OP_N_LOW;
            state <= item.err ? S_OUT : S_MSTART;
          end
        end
        S_MSTART: state <= S_MWAIT;
        S_MWAIT: begin
          if (mul_done) begin
            if (op == OP_NUM) begin
              state <= S_NORM;
            end else begin
              op    <= op_t'(op + 3'd1);
              state <= S_MSTART;
            end
          end
        end
        S_NORM:  state <= (den == '0) ? S_OUT : S_TOP;
        S_TOP:   state <= S_ABS;
        S_ABS:   state <= S_CHK;
        S_CHK:   state <= ({2'b0, top} >= dsh) ? S_OUT : S_DIV;
        S_DIV:   state <= (cnt == '0) ? S_FIN : S_DIV;
        S_FIN:   state <= S_OUT;
        S_OUT:   state <= load ? S_IDLE : S_OUT;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        l0        <= item.l0;
        l1        <= item.l1;
        l2        <= item.l2;
        d         <= signed'(item.d);
        bx        <= {item.x, 24'b0};
        temp      <= item.temp;
        res_press <= '0;
        res_err   <= 1'b1;
      end
      S_MWAIT: begin
        if (mul_done) begin
          case (op)
            OP_N_LOW: accn <= mul_p;
            OP_N_MID: accn <= accn - mul_p;
            OP_N_UP:  accn <= accn - mul_p;
            OP_DEN:   den  <= accn + mul_p;
            OP_SPAN:  e    <= mul_p[OPA_W-1:0];
            OP_NUM:   num  <= mul_p;
            default:  accn <= accn;
          endcase
        end
      end
      S_NORM: begin
        // keep the divisor positive
        if (den[PROD_W-1]) begin
          den <= -den;
          num <= -num;
        end
      end
      S_TOP: begin
        // round to nearest: (2*num + den) / (2*den)
        top <= (num <<< 1) + den;
        dsh <= DSH_W'(den) << (DIV_BITS + 1);
      end
      S_ABS: begin
        neg <= top[PROD_W-1];
        top <= top[PROD_W-1] ? -top : top;
      end
      S_CHK: begin
        if ({2'b0, top} >= dsh) begin
          res_press <= neg ? '0 : PRESS_MAX;
        end
        dsh <= dsh >> 1;
        cnt <= DIVC_W'(DIV_BITS - 1);
        q   <= '0;
      end
      S_DIV: begin
        if ({2'b0, top} >= dsh) begin
          top <= top - signed'(dsh[PROD_W-1:0]);
          q   <= {q[DIV_BITS-2:0], 1'b1};
        end else begin
          q   <= {q[DIV_BITS-2:0], 1'b0};
        end
        dsh <= dsh >> 1;
        cnt <= cnt - 1'b1;
      end
      S_FIN: begin
        if (neg) begin
          if (qa > P0_SIXTEENTHS) begin
            res_press <= '0;
            res_err   <= 1'b1;
          end else begin
            res_press <= PRESS_W'(P0_SIXTEENTHS - qa);
            res_err   <= 1'b0;
          end
        end else if (qa > POS_LIMIT) begin
          res_press <= PRESS_MAX;
          res_err   <= 1'b1;
        end else begin
          res_press <= PRESS_W'(P0_SIXTEENTHS + qa);
          res_err   <= 1'b0;
        end
      end
      default: begin
        res_err <= res_err;
      end
    endcase
    if (load) begin
      pressure_sixteenth_pa <= res_press;
      temperature_centi_c   <= signed'(temp);
      calc_error            <= res_err;
    end
  end

endmodule

// ===== rtl/baro_pressure_compensation.sv =====
// ----------------------------------------------------------------------------
// baro_pressure_compensation
// Raw pressure and temperature to compensated pressure and temperature.
// ----------------------------------------------------------------------------
// Usage:
//   Write the four factory calibration words through cfg_we/cfg_index/
//   cfg_data while the block is idle; reset clears them to zero.
//   Present a request (raw_pressure, raw_temperature) with in_valid; it is
//   taken on a cycle where in_valid and in_ready are both high. One result
//   per request leaves on out_valid/out_ready, in request order.
//   The front takes a request every cycle while in_ready is high, into a
//   three-stage pipeline and a two-entry queue, so several requests can
//   be in flight at once. The back runs one request at a time: six
//   multiplies on a shared 32x32 unit and a 22-step restoring divider
//   dominate its work; requests whose table points give a zero divisor
//   skip both and go straight to the output register.
//   When the receiver holds out_ready low, the result stays in the output
//   register; the back then waits, the queue fills, and in_ready drops.
//   Reset empties the pipeline, the queue and the output register.
// ----------------------------------------------------------------------------
module baro_pressure_compensation import bpc_pkg::*; #(
  parameter int QueueDepth = QUEUE_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_index,
  input  logic [CAL_W-1:0]         cfg_data,
  input  logic [X_W-1:0]           raw_pressure,
  input  logic [TR_W-1:0]          raw_temperature,
  input  logic                     in_valid,
  output logic                     in_ready,
  output logic [PRESS_W-1:0]       pressure_sixteenth_pa,
  output logic signed [TEMP_W-1:0] temperature_centi_c,
  output logic                     calc_error,
  output logic                     out_valid,
  input  logic                     out_ready
);

  bpc_cal_t  cal;
  bpc_item_t f_item, q_item;
  logic      f_valid, f_ready, q_valid, q_ready;

  // calibration registers; the user must write them only while idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      cal <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_CAL_ZERO:  cal.zero  <= cfg_data;
        CFG_CAL_ONE:   cal.one   <= cfg_data;
        CFG_CAL_TWO:   cal.two   <= cfg_data;
        CFG_CAL_THREE: cal.three <= cfg_data;
      endcase
    end
  end

  // front: temperature, table points and zero-divisor classification
  bpc_front u_front (
    .clk             (clk),
    .rst             (rst),
    .cal             (cal),
    .raw_pressure    (raw_pressure),
    .raw_temperature (raw_temperature),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .item            (f_item),
    .item_valid      (f_valid),
    .item_ready      (f_ready)
  );

  // decouple front and back
  bpc_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_data  (f_item),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .rd_data  (q_item),
    .rd_valid (q_valid),
    .rd_ready (q_ready)
  );

  // back: conversion constants, division, rounding, saturation
  bpc_back u_back (
    .clk                   (clk),
    .rst                   (rst),
    .item                  (q_item),
    .item_valid            (q_valid),
    .item_ready            (q_ready),
    .pressure_sixteenth_pa (pressure_sixteenth_pa),
    .temperature_centi_c   (temperature_centi_c),
    .calc_error            (calc_error),
    .out_valid             (out_valid),
    .out_ready             (out_ready)
  );

endmodule

// ===== sim/baro_pressure_compensation_tb.sv =====
// ----------------------------------------------------------------------------
// baro_pressure_compensation_tb
// Self-checking bench for the barometric pressure compensation: a typed-in
// table of directed readings, then randomized readings under several sets of
// calibration words, all checked field by field against a typed answer or an exact predictor.
// ----------------------------------------------------------------------------
module baro_pressure_compensation_tb import bpc_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RAND_READINGS = 450;
  localparam int QUIET_TAIL    = 60;     // last readings with no idling at all
  localparam int HOLD_CYCLES   = 400;    // long receiver hold-off
  localparam int SETTLE_CYCLES = 150;    // a little above the block latency
  localparam int STALL_LIMIT   = 6000;   // cycles with no handshake at all

  typedef struct {
    logic [PRESS_W-1:0]       press;
    logic signed [TEMP_W-1:0] temp;
    logic                     err;
  } reading_t;

  // Directed row: raw sample and, where obvious, the typed-in answer.
  typedef struct {
    logic [X_W-1:0]           x;
    logic [TR_W-1:0]          traw;
    bit                       typed;
    logic [PRESS_W-1:0]       press;
    logic signed [TEMP_W-1:0] temp;
    logic                     err;
  } row_t;

  logic                     clk;
  logic                     rst;
  logic                     cfg_we;
  logic [1:0]               cfg_index;
  logic [CAL_W-1:0]         cfg_data;
  logic [X_W-1:0]           raw_pressure;
  logic [TR_W-1:0]          raw_temperature;
  logic                     in_valid;
  logic                     in_ready;
  logic [PRESS_W-1:0]       pressure_sixteenth_pa;
  logic signed [TEMP_W-1:0] temperature_centi_c;
  logic                     calc_error;
  logic                     out_valid;
  logic                     out_ready;

  logic [CAL_W-1:0] cal_words [4];       // shadow copy of the calibration
  reading_t         pending_readings [$];
  int               mismatches;
  int               readings_in;
  int               readings_out;
  int               error_flags;
  int               stall_cycles;
  bit               quiet;               // no idling on either side
  bit               hold_request;        // sender asks receiver for a hold-off

  baro_pressure_compensation i_dut (.*);

  // Clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Signed 64 x 64 product kept to 128 bits, as the block keeps it.
  function automatic logic [127:0] wide_mul(input longint a, input longint b);
    logic signed [127:0] wa;
    logic signed [127:0] wb;
    wa = a;
    wb = b;
    return wa * wb;
  endfunction

  // Exact three-point conversion for one raw sample under cal_words.
  function automatic reading_t compensate(input logic [X_W-1:0] x,
                                          input logic [TR_W-1:0] traw);
    longint t_c, tt, l0, l1, l2, bx, d;
    logic [127:0] n, den, num, top, d2, q, r;
    logic [31:0] tscaled;
    logic neg;
    reading_t o;
    t_c = longint'({16'd0, traw}) - 32768;
    tt  = t_c * t_c;
    l0  = (longint'(7) <<< 43) + longint'({48'd0, cal_words[0]}) * tt;
    l1  = (longint'({48'd0, cal_words[3]}) <<< 35) + longint'({48'd0, cal_words[1]}) * tt;
    l2  = (longint'(23) <<< 43) + longint'({48'd0, cal_words[2]}) * tt;
    bx  = longint'({40'd0, x}) <<< 24;
    d   = 12 * l1 - 7 * l2 - 5 * l0;
    o.press = '0;
    o.err   = 1'b0;
    if (d == 0 || l0 == l1) begin
      o.err = 1'b1;
    end else begin
      n   = 128'd12 * wide_mul(l2, l0) - 128'd7 * wide_mul(l0, l1)
            - 128'd5 * wide_mul(l1, l2);
      den = n + wide_mul(bx, d);
      num = wide_mul(l1 - l2, bx - l0) * 128'd6720000;
      if (den == 0) begin
        o.err = 1'b1;
      end else begin
        // Normalize to a positive divisor, then round half toward +inf.
        if (den[127]) begin
          den = -den;
          num = -num;
        end
        top = (num << 1) + den;
        d2  = den << 1;
        neg = top[127];
        if (neg) top = -top;
        q = top / d2;
        r = top % d2;
        if (neg && r != 0) q = q + 1;
        if (neg) begin
          if (q > 128'd720000) o.err = 1'b1;
          else o.press = PRESS_W'(128'd720000 - q);
        end else if (q > 128'd1377151) begin
          o.press = PRESS_MAX;
          o.err   = 1'b1;
        end else begin
          o.press = PRESS_W'(128'd720000 + q);
        end
      end
    end
    tscaled = (32'd17500 * {16'd0, traw} + 32'd32768) >> 16;
    o.temp  = TEMP_W'(int'(tscaled) - 4500);
    return o;
  endfunction

  // Write one calibration word; call only while the block is idle.
  task automatic write_cal(input cfg_reg_t idx, input logic [CAL_W-1:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk);
    cfg_we = 1'b0;
    cal_words[idx] = value;
  endtask

  task automatic write_all_cal(input logic [CAL_W-1:0] w0, input logic [CAL_W-1:0] w1,
                               input logic [CAL_W-1:0] w2, input logic [CAL_W-1:0] w3);
    write_cal(CFG_CAL_ZERO, w0);
    write_cal(CFG_CAL_ONE, w1);
    write_cal(CFG_CAL_TWO, w2);
    write_cal(CFG_CAL_THREE, w3);
  endtask

  // Drop valid, drain every outstanding reading, then let the back end settle.
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Offer one request and hold it until taken; queue its expected reading.
  task automatic send_reading(input logic [X_W-1:0] x, input logic [TR_W-1:0] traw,
                              input bit typed, input reading_t typed_exp);
    @(negedge clk);
    raw_pressure    = x;
    raw_temperature = traw;
    in_valid        = 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_readings.push_back(typed ? typed_exp : compensate(x, traw));
    readings_in++;
    // Drop valid for a burst now and then.
    if (!quiet && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(1, 7) - 1) @(negedge clk);
    end
  endtask

  // Random raw sample: mostly inside the table span, sometimes anywhere,
  // with the temperature extremes showing up often.
  task automatic send_random();
    logic [X_W-1:0]  x;
    logic [TR_W-1:0] traw;
    reading_t none;
    none = '{default: '0};
    case ($urandom_range(0, 9))
      0:       x = X_W'($urandom);
      1:       x = $urandom_range(0, 1) ? '1 : '0;
      default: x = X_W'($urandom_range(3000000, 13000000));
    endcase
    case ($urandom_range(0, 7))
      0:       traw = '0;
      1:       traw = '1;
      2:       traw = TR_W'($urandom_range(32700, 32836));
      default: traw = TR_W'($urandom);
    endcase
    send_reading(x, traw, 1'b0, none);
  endtask

  // Receiver: random stall bursts, one long hold-off on request.
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_request && !hold_done) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
        out_ready = 1'b1;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 7) - 1) @(negedge clk);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // Compare each taken result with the oldest expectation.
  always @(posedge clk) begin
    reading_t want;
    if (!rst && out_valid && out_ready) begin
      readings_out++;
      if (calc_error) error_flags++;
      if (pending_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result p=%0d t=%0d e=%0b",
                   pressure_sixteenth_pa, temperature_centi_c, calc_error);
      end else begin
        want = pending_readings.pop_front();
        if (pressure_sixteenth_pa !== want.press || temperature_centi_c !== want.temp ||
            calc_error !== want.err) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: result %0d exp p=%0d t=%0d e=%0b got p=%0d t=%0d e=%0b",
                     readings_out, want.press, want.temp, want.err,
                     pressure_sixteenth_pa, temperature_centi_c, calc_error);
        end
      end
    end
  end

  // Watchdog: count cycles in which neither side hands anything over.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("ERROR: no handshake for %0d cycles", STALL_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Main sequence.
  initial begin
    row_t     rows [$];
    int       sent;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_CAL_ZERO;
    cfg_data = '0;
    raw_pressure = '0;
    raw_temperature = '0;
    in_valid = 1'b0;
    quiet = 1'b0;
    hold_request = 1'b0;
    mismatches = 0;
    readings_in = 0;
    readings_out = 0;
    error_flags = 0;
    sent = 0;
    foreach (cal_words[i]) cal_words[i] = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Calibration left at reset: field extremes and temperature ends.
    rows = '{
      '{24'd0,        16'd0,     1'b0, 21'd0, 15'sd0,     1'b0},
      '{24'hFFFFFF,   16'hFFFF,  1'b0, 21'd0, 15'sd0,     1'b0},
      '{24'd3670016,  16'd32768, 1'b0, 21'd0, 15'sd0,     1'b0},
      '{24'd12058624, 16'd32768, 1'b0, 21'd0, 15'sd0,     1'b0},
      '{24'h800000,   16'h8000,  1'b0, 21'd0, 15'sd0,     1'b0},
      '{24'h555555,   16'hAAAA,  1'b0, 21'd0, 15'sd0,     1'b0},
      '{24'hAAAAAA,   16'h5555,  1'b0, 21'd0, 15'sd0,     1'b0}
    };
    foreach (rows[i])
      send_reading(rows[i].x, rows[i].traw, rows[i].typed,
                   '{rows[i].press, rows[i].temp, rows[i].err});
    drain();

    // Low and middle points coincide: zero divisor at any sample.
    write_all_cal(16'd77, 16'd77, 16'd400, 16'd1792);
    rows = '{
      '{24'd0,       16'd0,     1'b1, 21'd0, -15'sd4500, 1'b1},
      '{24'hFFFFFF,  16'hFFFF,  1'b1, 21'd0, 15'sd13000, 1'b1},
      '{24'd7000000, 16'd32768, 1'b0, 21'd0, 15'sd0,     1'b0},
      '{24'd123456,  16'd1000,  1'b0, 21'd0, 15'sd0,     1'b0}
    };
    foreach (rows[i])
      send_reading(rows[i].x, rows[i].traw, rows[i].typed,
                   '{rows[i].press, rows[i].temp, rows[i].err});
    drain();

    // Plausible factory words: in range, saturated high and below range.
    write_all_cal(16'd1200, 16'd1800, 16'd2600, 16'd3840);
    rows = '{
      '{24'd3670016,  16'd30000, 1'b0, 21'd0, 15'sd0, 1'b0},
      '{24'd8000000,  16'd40000, 1'b0, 21'd0, 15'sd0, 1'b0},
      '{24'd12058624, 16'd20000, 1'b0, 21'd0, 15'sd0, 1'b0},
      '{24'hFFFFFF,   16'd32768, 1'b0, 21'd0, 15'sd0, 1'b0},
      '{24'd1,        16'd32768, 1'b0, 21'd0, 15'sd0, 1'b0},
      '{24'd2500000,  16'd0,     1'b0, 21'd0, 15'sd0, 1'b0},
      '{24'd14000000, 16'hFFFF,  1'b0, 21'd0, 15'sd0, 1'b0}
    };
    foreach (rows[i])
      send_reading(rows[i].x, rows[i].traw, rows[i].typed,
                   '{rows[i].press, rows[i].temp, rows[i].err});
    drain();

    // Random phases, each under a fresh calibration; extremes come first.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       write_all_cal('1, '1, '1, '1);
        1:       write_all_cal('0, '0, '0, '0);
        default: write_all_cal(CAL_W'($urandom_range(0, 4000)),
                               CAL_W'($urandom_range(0, 4000)),
                               CAL_W'($urandom_range(0, 65535)),
                               CAL_W'($urandom_range(3000, 4500)));
      endcase
      for (int k = 0; k < RAND_READINGS / 6; k++) begin
        quiet = (sent >= RAND_READINGS - QUIET_TAIL);
        // Once, in the middle of a phase, hold the output long enough
        // for the queue to fill and stall the input.
        if (phase == 2 && k == 20) hold_request = 1'b1;
        send_random();
        sent++;
      end
      @(negedge clk);
      in_valid = 1'b0;
      drain();
    end

    $display("Covered %0d readings, %0d error flags, under 9 calibration sets,",
             readings_in, error_flags);
    $display("including all-zero and all-ones words and one long output hold-off.");
    if (mismatches == 0 && pending_readings.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending_readings.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
